/* hdl/fcr_pkg.sv */
// Package: shared types and constants for the framed command receiver.
`default_nettype none
package fcr_pkg;

   localparam logic [7:0] SYNC_A = 8'hA5;
   localparam logic [7:0] SYNC_B = 8'h5A;
   localparam logic [7:0] PROTO_VERSION = 8'd1;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] YAW_LIMIT = 16'd36000;
   localparam logic [15:0] ACC_LIMIT = 16'd18000;

   localparam logic [2:0] CSR_HB_TIMEOUT = 3'd0;
   localparam logic [2:0] CSR_SP_TIMEOUT = 3'd1;
   localparam logic [2:0] CSR_HD_TIMEOUT = 3'd2;
   localparam logic [2:0] CSR_MAX_ANGLE = 3'd3;
   localparam logic [2:0] CSR_MAX_ALT = 3'd4;

   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_OVERLONG = 3'd1;
   localparam logic [2:0] EV_CRC_BAD = 3'd2;
   localparam logic [2:0] EV_REJECT = 3'd3;
   localparam logic [2:0] EV_IGNORED = 3'd4;
   localparam logic [2:0] EV_HEARTBEAT = 3'd5;
   localparam logic [2:0] EV_SETPOINT = 3'd6;
   localparam logic [2:0] EV_HEADING = 3'd7;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_HDR   = 3'd2,
      PH_PAY   = 3'd3,
      PH_CRCL  = 3'd4,
      PH_CRCH  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_FRAME = 2'd1,
      CMD_TICK = 2'd2,
      CMD_EVENT = 2'd3
   } cmd_kind_type;

   // one classified transfer from the front end to the back end
   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0] event_code;
      logic [7:0] version;
      logic [7:0] ftype;
      logic [7:0] flen;
      logic [15:0] seq;
      logic [79:0] payload;
      logic [31:0] now_us;
      logic switch_active;
      logic [11:0] yaw;
   } cmd_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* hdl/fcr_front.sv */
// Front end: frame parser with running CRC, emits one command per byte or tick.
`default_nettype none
module fcr_front #(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic in_type,
   input  wire logic [7:0] in_byte,
   input  wire logic [31:0] in_now,
   input  wire logic in_switch,
   input  wire logic [11:0] in_yaw,
   output fcr_pkg::cmd_type cmd
);
   import fcr_pkg::*;

   localparam int IW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [7:0] MAXP = 8'(MAX_PAYLOAD);

   phase_type phase_ff, phase_in;
   logic [2:0] hidx_ff, hidx_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0] rcrc_lo_ff, rcrc_lo_in;
   logic [7:0] hdr_ff [5];
   logic [7:0] pay_ff [10];
   logic [7:0] len_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         hidx_ff <= '0;
         pidx_ff <= '0;
         crc_ff <= CRC_INIT;
         rcrc_lo_ff <= '0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
         hidx_ff <= hidx_in;
         pidx_ff <= pidx_in;
         crc_ff <= crc_in;
         rcrc_lo_ff <= rcrc_lo_in;
      end
   end

   // header and first payload bytes only: the decoder uses no later bytes
   always_ff @(posedge clock) begin
      if (in_valid && !in_type) begin
         if (phase_ff == PH_HDR && hidx_ff < 3'd5) hdr_ff[hidx_ff] <= in_byte;
         if (phase_ff == PH_PAY) begin
            for (int k = 0; k < 10; k++) begin
               if (pidx_ff == IW'(k)) pay_ff[k] <= in_byte;
            end
         end
      end
   end

   // the length is the third header byte, already stored by the last header byte
   assign len_now = hdr_ff[2];

   always_comb begin
      phase_in = phase_ff;
      hidx_in = hidx_ff;
      pidx_in = pidx_ff;
      crc_in = crc_ff;
      rcrc_lo_in = rcrc_lo_ff;
      cmd = '0;
      cmd.now_us = in_now;
      cmd.switch_active = in_switch;
      cmd.yaw = in_yaw;
      cmd.version = hdr_ff[0];
      cmd.ftype = hdr_ff[1];
      cmd.flen = hdr_ff[2];
      cmd.seq = {hdr_ff[4], hdr_ff[3]};
      for (int k = 0; k < 10; k++) cmd.payload[8*k +: 8] = pay_ff[k];
      cmd.kind = CMD_NONE;
      cmd.event_code = EV_NONE;
      if (in_type) begin
         cmd.kind = CMD_TICK;
      end else begin
         cmd.kind = CMD_EVENT;
         unique case (phase_ff)
            PH_SYNC2: begin
               if (in_byte == SYNC_B) begin
                  phase_in = PH_HDR;
                  hidx_in = '0;
                  crc_in = CRC_INIT;
               end else begin
                  phase_in = (in_byte == SYNC_A) ? PH_SYNC2 : PH_SYNC1;
               end
            end
            PH_HDR: begin
               crc_in = crc_byte(crc_ff, in_byte);
               if (hidx_ff >= 3'd4) begin
                  if (len_now > MAXP) begin
                     phase_in = PH_SYNC1;
                     hidx_in = '0;
                     pidx_in = '0;
                     cmd.event_code = EV_OVERLONG;
                  end else if (len_now == 8'd0) begin
                     phase_in = PH_CRCL;
                     hidx_in = hidx_ff + 3'd1;
                  end else begin
                     phase_in = PH_PAY;
                     pidx_in = '0;
                     hidx_in = hidx_ff + 3'd1;
                  end
               end else begin
                  hidx_in = hidx_ff + 3'd1;
               end
            end
            PH_PAY: begin
               crc_in = crc_byte(crc_ff, in_byte);
               pidx_in = pidx_ff + IW'(1);
               if (8'(pidx_ff) + 8'd1 >= hdr_ff[2]) phase_in = PH_CRCL;
            end
            PH_CRCL: begin
               rcrc_lo_in = in_byte;
               phase_in = PH_CRCH;
            end
            PH_CRCH: begin
               if ({in_byte, rcrc_lo_ff} == crc_ff) cmd.kind = CMD_FRAME;
               else cmd.event_code = EV_CRC_BAD;
               phase_in = PH_SYNC1;
               hidx_in = '0;
               pidx_in = '0;
            end
            default: begin
               phase_in = (in_byte == SYNC_A) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (8'(pidx_ff) < hdr_ff[2]))
      else $error("payload index passed frame length");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HDR) |-> (hidx_ff < 3'd5))
      else $error("header index overran");
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && !in_type && phase_ff == PH_CRCL) |=> (phase_ff == PH_CRCH))
      else $error("crc low byte not followed by high phase");
endmodule
`default_nettype wire

/* hdl/fcr_queue.sv */
// Two-entry queue between the front end and the back end.
`default_nettype none
module fcr_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  fcr_pkg::cmd_type push_data,
   input  wire logic pop,
   output logic full,
   output logic not_empty,
   output fcr_pkg::cmd_type head
);
   import fcr_pkg::*;

   cmd_type mem_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head = mem_ff[rp_ff];
   assign wp_in = wp_ff ^ push;
   assign rp_in = rp_ff ^ pop;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
endmodule
`default_nettype wire

/* hdl/fcr_back.sv */
// Back end: frame acceptance, register updates, freshness, result register.
`default_nettype none
module fcr_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   input  fcr_pkg::cmd_type cmd,
   output logic cmd_pop,
   input  wire logic [30:0] hb_timeout,
   input  wire logic [30:0] sp_timeout,
   input  wire logic [30:0] hd_timeout,
   input  wire logic [14:0] max_angle,
   input  wire logic [30:0] max_alt,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [2:0] rsp_event_code,
   output logic rsp_control_active,
   output logic signed [15:0] rsp_roll_cdeg,
   output logic signed [15:0] rsp_pitch_cdeg,
   output logic [15:0] rsp_target_yaw_cdeg,
   output logic [30:0] rsp_altitude_cm,
   output logic [15:0] rsp_heading_cdeg,
   output logic [14:0] rsp_heading_accuracy_cdeg,
   output logic signed [11:0] rsp_heading_ref_yaw_decideg
);
   import fcr_pkg::*;

   logic [15:0] last_seq_ff, last_seq_in;
   logic seq_valid_ff, seq_valid_in;
   logic [15:0] roll_ff, roll_in, pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic [30:0] alt_ff, alt_in;
   logic [15:0] hdg_ff, hdg_in;
   logic [14:0] acc_ff, acc_in;
   logic [11:0] ref_ff, ref_in;
   logic [31:0] t_ff [3];
   logic [31:0] t_in [3];
   logic [2:0] seen_ff, seen_in;
   logic sw_was_ff, sw_was_in, ctrl_ff, ctrl_in;
   logic [2:0] ev;
   logic [15:0] delta, p_roll, p_pitch, p_yaw, p_hdg, p_acc;
   logic [31:0] p_alt;
   logic signed [16:0] lim, sroll, spitch;
   logic seq_ok, rng_ok;
   logic [2:0] fresh;
   logic [30:0] tmo [3];
   logic [31:0] age [3];
   logic out_free;

   assign out_free = !rsp_valid || !rsp_stall;
   assign cmd_pop = cmd_valid && out_free;

   assign tmo[0] = hb_timeout;
   assign tmo[1] = sp_timeout;
   assign tmo[2] = hd_timeout;

   always_comb begin
      p_roll = cmd.payload[15:0];
      p_pitch = cmd.payload[31:16];
      p_yaw = cmd.payload[47:32];
      p_alt = cmd.payload[79:48];
      p_hdg = cmd.payload[15:0];
      p_acc = cmd.payload[31:16];
      lim = signed'({2'b00, max_angle});
      sroll = signed'({p_roll[15], p_roll});
      spitch = signed'({p_pitch[15], p_pitch});
      delta = cmd.seq - last_seq_ff;
      seq_ok = !seq_valid_ff || (delta != 16'd0 && !delta[15]);
      for (int i = 0; i < 3; i++) begin
         age[i] = cmd.now_us - t_ff[i];
         fresh[i] = seen_ff[i] && (age[i][31] || age[i][30:0] <= tmo[i]);
      end

      last_seq_in = last_seq_ff;
      seq_valid_in = seq_valid_ff;
      roll_in = roll_ff;
      pitch_in = pitch_ff;
      yaw_in = yaw_ff;
      alt_in = alt_ff;
      hdg_in = hdg_ff;
      acc_in = acc_ff;
      ref_in = ref_ff;
      t_in = t_ff;
      seen_in = seen_ff;
      sw_was_in = sw_was_ff;
      ctrl_in = ctrl_ff;
      rng_ok = 1'b0;
      ev = cmd.event_code;

      case (cmd.kind)
         CMD_FRAME: begin
            if (cmd.version != PROTO_VERSION || !seq_ok) begin
               ev = EV_REJECT;
            end else begin
               seq_valid_in = 1'b1;
               last_seq_in = cmd.seq;
               ev = EV_IGNORED;
               if (cmd.ftype == 8'd1 && cmd.flen == 8'd8) begin
                  ev = EV_HEARTBEAT;
                  t_in[0] = cmd.now_us;
                  seen_in[0] = seen_ff[0] | cmd.switch_active;
               end else if (cmd.ftype == 8'd2 && cmd.flen == 8'd10) begin
                  rng_ok = sroll >= -lim && sroll <= lim && spitch >= -lim && spitch <= lim
                     && p_yaw < YAW_LIMIT && !p_alt[31] && p_alt[30:0] <= max_alt;
                  if (rng_ok) begin
                     ev = EV_SETPOINT;
                     roll_in = p_roll;
                     pitch_in = p_pitch;
                     yaw_in = p_yaw;
                     alt_in = p_alt[30:0];
                     t_in[1] = cmd.now_us;
                     seen_in[1] = seen_ff[1] | cmd.switch_active;
                  end
               end else if (cmd.ftype == 8'd3 && cmd.flen == 8'd4) begin
                  if (p_hdg < YAW_LIMIT && p_acc <= ACC_LIMIT) begin
                     ev = EV_HEADING;
                     hdg_in = p_hdg;
                     acc_in = p_acc[14:0];
                     ref_in = cmd.yaw;
                     t_in[2] = cmd.now_us;
                     seen_in[2] = seen_ff[2] | cmd.switch_active;
                  end
               end
            end
         end
         CMD_TICK: begin
            ev = EV_NONE;
            if (!cmd.switch_active) ctrl_in = 1'b0;
            else if (!sw_was_ff) ctrl_in = 1'b0;
            else ctrl_in = &fresh;
            if (cmd.switch_active && !sw_was_ff) seen_in = '0;
            sw_was_in = cmd.switch_active;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= '0;
         seq_valid_ff <= 1'b0;
         roll_ff <= '0;
         pitch_ff <= '0;
         yaw_ff <= '0;
         alt_ff <= '0;
         hdg_ff <= '0;
         acc_ff <= '0;
         ref_ff <= '0;
         for (int i = 0; i < 3; i++) t_ff[i] <= '0;
         seen_ff <= '0;
         sw_was_ff <= 1'b0;
         ctrl_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (cmd_pop) begin
            last_seq_ff <= last_seq_in;
            seq_valid_ff <= seq_valid_in;
            roll_ff <= roll_in;
            pitch_ff <= pitch_in;
            yaw_ff <= yaw_in;
            alt_ff <= alt_in;
            hdg_ff <= hdg_in;
            acc_ff <= acc_in;
            ref_ff <= ref_in;
            t_ff <= t_in;
            seen_ff <= seen_in;
            sw_was_ff <= sw_was_in;
            ctrl_ff <= ctrl_in;
         end
         if (out_free) rsp_valid <= cmd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_event_code <= ev;
         rsp_control_active <= ctrl_in;
         rsp_roll_cdeg <= signed'(roll_in);
         rsp_pitch_cdeg <= signed'(pitch_in);
         rsp_target_yaw_cdeg <= yaw_in;
         rsp_altitude_cm <= alt_in;
         rsp_heading_cdeg <= hdg_in;
         rsp_heading_accuracy_cdeg <= acc_in;
         rsp_heading_ref_yaw_decideg <= signed'(ref_in);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.kind == CMD_TICK && !cmd.switch_active) |=> !ctrl_ff)
      else $error("control stayed on with switch off");
   assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.kind == CMD_TICK) |=> (rsp_event_code == EV_NONE))
      else $error("tick produced an event");
endmodule
`default_nettype wire

/* hdl/framed_command_receiver_with_freshness_top.sv */
// Top level: framed command receiver with freshness supervision.
// Throughput: one transfer per cycle while the queue is not full (req_stall low); the
// front end parses one byte per cycle with a byte-wide CRC step, and the back end
// retires one command per cycle while the result register is not held by rsp_stall.
// A two-entry queue decouples the parser from the result register.
// Reset (synchronous, active high) clears parser, sequence, setpoint and freshness state.
`default_nettype none
module framed_command_receiver_with_freshness_top #(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic req_type,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic [31:0] req_now_us,
   input  wire logic req_switch_active,
   input  wire logic signed [11:0] req_local_yaw_decideg,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [2:0] rsp_event_code,
   output logic rsp_control_active,
   output logic signed [15:0] rsp_roll_cdeg,
   output logic signed [15:0] rsp_pitch_cdeg,
   output logic [15:0] rsp_target_yaw_cdeg,
   output logic [30:0] rsp_altitude_cm,
   output logic [15:0] rsp_heading_cdeg,
   output logic [14:0] rsp_heading_accuracy_cdeg,
   output logic signed [11:0] rsp_heading_ref_yaw_decideg,
   input  wire logic csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [30:0] csr_data
);
   import fcr_pkg::*;

   logic [30:0] hb_tmo_ff, sp_tmo_ff, hd_tmo_ff, max_alt_ff;
   logic [14:0] max_angle_ff;
   cmd_type front_cmd, q_head;
   logic q_full, q_ne, q_pop, accept;

   // hold configuration; writes outside the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         hb_tmo_ff <= 31'd3000000;
         sp_tmo_ff <= 31'd500000;
         hd_tmo_ff <= 31'd500000;
         max_angle_ff <= 15'd6000;
         max_alt_ff <= 31'd100000;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HB_TIMEOUT: hb_tmo_ff <= csr_data;
            CSR_SP_TIMEOUT: sp_tmo_ff <= csr_data;
            CSR_HD_TIMEOUT: hd_tmo_ff <= csr_data;
            CSR_MAX_ANGLE: max_angle_ff <= csr_data[14:0];
            CSR_MAX_ALT: max_alt_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // stall input while the queue is full
   assign req_stall = q_full;
   assign accept = req_valid && !req_stall;

   fcr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock(clock), .reset(reset), .in_valid(accept), .in_type(req_type),
      .in_byte(req_rx_byte), .in_now(req_now_us), .in_switch(req_switch_active),
      .in_yaw(req_local_yaw_decideg), .cmd(front_cmd)
   );

   fcr_queue u_queue (
      .clock(clock), .reset(reset), .push(accept), .push_data(front_cmd),
      .pop(q_pop), .full(q_full), .not_empty(q_ne), .head(q_head)
   );

   fcr_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(q_ne), .cmd(q_head), .cmd_pop(q_pop),
      .hb_timeout(hb_tmo_ff), .sp_timeout(sp_tmo_ff), .hd_timeout(hd_tmo_ff),
      .max_angle(max_angle_ff), .max_alt(max_alt_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_event_code(rsp_event_code), .rsp_control_active(rsp_control_active),
      .rsp_roll_cdeg(rsp_roll_cdeg), .rsp_pitch_cdeg(rsp_pitch_cdeg),
      .rsp_target_yaw_cdeg(rsp_target_yaw_cdeg), .rsp_altitude_cm(rsp_altitude_cm),
      .rsp_heading_cdeg(rsp_heading_cdeg),
      .rsp_heading_accuracy_cdeg(rsp_heading_accuracy_cdeg),
      .rsp_heading_ref_yaw_decideg(rsp_heading_ref_yaw_decideg)
   );

   assert property (@(posedge clock) disable iff (reset) q_full |-> q_ne)
      else $error("queue full but empty");
   assert property (@(posedge clock) disable iff (reset)
      (q_ne && !rsp_stall) |-> q_pop)
      else $error("back end idle with work and free output");
   assert property (@(posedge clock) disable iff (reset) q_pop |=> rsp_valid)
      else $error("popped command gave no result");
endmodule
`default_nettype wire
